FILE: design/hbes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbes_pkg: shared types and constants for the height band erosion select
// Register indexes, reset values, queue sizing, sequencer states and the
// structs passed between the front end, the result queue and the top level.
// ----------------------------------------------------------------------------
package hbes_pkg;

   // sizing of fields
   localparam int POS_W    = 32;
   localparam int IDX_W    = 20;
   localparam int LINE_W   = 3 * POS_W;
   localparam int GW_W     = 11;
   localparam int CSR_W    = 32;
   localparam int CSR_A_W  = 2;

   localparam int DEFAULT_MAX_GRID_WIDTH = 1024;
   localparam int MIN_GRID_WIDTH         = 3;

   // register indexes
   localparam logic [CSR_A_W-1:0] REG_GRID_WIDTH = 2'd0;
   localparam logic [CSR_A_W-1:0] REG_MIN_HEIGHT = 2'd1;
   localparam logic [CSR_A_W-1:0] REG_MAX_HEIGHT = 2'd2;

   // register reset values
   localparam int                        GRID_WIDTH_RESET_INT = 256;
   localparam logic [GW_W-1:0]           GRID_WIDTH_RESET     = 11'd256;
   localparam logic signed [POS_W-1:0]   MIN_HEIGHT_RESET     = 32'sd0;
   localparam logic signed [POS_W-1:0]   MAX_HEIGHT_RESET     = 32'sd65536;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int LEVEL_W     = 3;

   // width resync sequencer
   typedef enum logic [1:0] {
      SYNC_IDLE,
      SYNC_SETUP,
      SYNC_MULT,
      SYNC_DIVIDE
   } hbes_sync_state_type;

   // configuration as seen by the front end
   typedef struct packed {
      logic                    width_wr;
      logic [GW_W-1:0]         grid_width;
      logic signed [POS_W-1:0] min_height;
      logic signed [POS_W-1:0] max_height;
   } hbes_cfg_type;

   // one result word
   typedef struct packed {
      logic [IDX_W-1:0]        sel_index;
      logic signed [POS_W-1:0] sel_z;
      logic signed [POS_W-1:0] sel_y;
      logic signed [POS_W-1:0] sel_x;
   } hbes_result_type;

   // push from the front end into the queue
   typedef struct packed {
      logic            valid;
      hbes_result_type data;
   } hbes_push_type;

endpackage

FILE: design/hbes_remainder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbes_remainder: bit-serial remainder unit
// Restoring division of the 20-bit raster index by the grid width, one
// dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module hbes_remainder
   import hbes_pkg::*;
#(
   parameter int WW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [IDX_W-1:0] dividend,
   input  logic [WW-1:0] divisor,
   output logic          done,
   output logic [WW-1:0] remainder
);

   localparam int CNT_W = $clog2(IDX_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] quo_ff, quo_in;
   logic [WW-1:0]    rem_ff, rem_in;
   logic [WW-1:0]    div_ff, div_in;
   logic [WW:0]      trial;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[IDX_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(IDX_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = WW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = WW'(trial);
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/hbes_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbes_front: vertex intake, band test and erosion window
// Accepts one vertex word per cycle while req_tready is high, tests its
// height against the band, keeps the band flags in a circular mask memory
// and the last row of positions in a line store, and decides in the next
// cycle if the centre vertex one row up survives four-neighbor erosion.
// ----------------------------------------------------------------------------
module hbes_front
   import hbes_pkg::*;
#(
   parameter int MAX_GRID_WIDTH = DEFAULT_MAX_GRID_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  hbes_cfg_type        cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [LINE_W-1:0]   req_tdata,
   input  logic [LEVEL_W-1:0]  q_level,
   output hbes_push_type       push
);

   localparam int WW = $clog2(MAX_GRID_WIDTH + 1);
   localparam int SW = $clog2(MAX_GRID_WIDTH);
   localparam int PW = $clog2(2 * MAX_GRID_WIDTH + 1);
   localparam int MD = 1 << PW;
   localparam int CW = (2 * WW > IDX_W + 1) ? 2 * WW : IDX_W + 1;
   localparam int W_RST = (GRID_WIDTH_RESET_INT > MAX_GRID_WIDTH) ?
                          MAX_GRID_WIDTH : GRID_WIDTH_RESET_INT;

   function automatic logic [WW-1:0] clamp_width(input logic [GW_W-1:0] g);
      logic [31:0] g32;
      g32 = 32'(g);
      if (g32 < 32'(MIN_GRID_WIDTH)) begin
         return WW'(MIN_GRID_WIDTH);
      end else if (g32 > 32'(MAX_GRID_WIDTH)) begin
         return WW'(MAX_GRID_WIDTH);
      end
      return WW'(g);
   endfunction

   // sequencer
   hbes_sync_state_type state_ff, state_in;

   // geometry and position
   logic [WW-1:0]    w_ff;
   logic [CW-1:0]    ww_ff;
   logic [IDX_W-1:0] n_ff;
   logic [SW-1:0]    slot_ff;
   logic [PW-1:0]    p_ff;
   logic [PW-1:0]    fill_ff;

   // window taps held in flops
   logic a1_ff, a2_ff;

   // memories
   logic              mask_mem [MD];
   logic [LINE_W-1:0] line_mem [MAX_GRID_WIDTH];

   // read stage
   logic              ra_ff, rb_ff, va_ff, vb_ff;
   logic [LINE_W-1:0] line_rd_ff;
   logic              prime_ff;
   logic              s1_valid_ff, s1_band_ff, s1_nok_ff;
   logic [IDX_W-1:0]  s1_index_ff;

   // remainder unit
   logic          rem_start, rem_done;
   logic [WW-1:0] rem_value;

   logic                    accept;
   logic                    prime_rd;
   logic signed [POS_W-1:0] py;
   logic                    band;
   logic [PW-1:0]           w_p;
   logic [PW-1:0]           addr_a, addr_b;
   logic                    val_a, val_b;
   logic                    n_ge;
   logic                    wrap;
   logic [WW-1:0]           slot_inc;
   logic                    ra_val, rb_val;
   logic                    emit;
   logic [LEVEL_W:0]        credit_use;

   hbes_remainder #(
      .WW(WW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (n_ff),
      .divisor   (w_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // sequencer: resync geometry and window after a width write
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SYNC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rem_start = 1'b0;
      prime_rd  = 1'b0;
      unique case (state_ff)
         SYNC_IDLE: begin
            if (cfg.width_wr) begin
               state_in = SYNC_SETUP;
            end
         end
         SYNC_SETUP: begin
            state_in = SYNC_MULT;
         end
         SYNC_MULT: begin
            // a newer width write restarts the resync
            if (cfg.width_wr) begin
               state_in = SYNC_SETUP;
            end else begin
               rem_start = 1'b1;
               prime_rd  = 1'b1;
               state_in  = SYNC_DIVIDE;
            end
         end
         SYNC_DIVIDE: begin
            if (cfg.width_wr) begin
               state_in = SYNC_SETUP;
            end else if (rem_done) begin
               state_in = SYNC_IDLE;
            end
         end
         default: state_in = SYNC_IDLE;
      endcase
   end

   // intake handshake: idle, no width write, room in the queue for all in flight
   assign credit_use = (LEVEL_W + 1)'(q_level) + (LEVEL_W + 1)'(s1_valid_ff);
   assign req_tready = (state_ff == SYNC_IDLE) && !cfg.width_wr &&
                       (credit_use < (LEVEL_W + 1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // band test of the incoming vertex
   assign py   = req_tdata[2*POS_W-1:POS_W];
   assign band = (cfg.min_height < py) && (py < cfg.max_height);

   // window tap addresses; priming reads the two older taps directly
   assign w_p    = PW'(w_ff);
   assign addr_a = prime_rd ? (p_ff - w_p) : (p_ff - w_p + PW'(1));
   assign addr_b = prime_rd ? (p_ff - w_p - PW'(1)) : (p_ff - (w_p << 1));
   assign val_a  = prime_rd ? (w_p <= fill_ff) : ((w_p - PW'(1)) <= fill_ff);
   assign val_b  = prime_rd ? ((w_p + PW'(1)) <= fill_ff) : ((w_p << 1) <= fill_ff);

   // counter stepping
   assign n_ge     = (CW'(n_ff) >= (CW'(w_ff) << 1));
   assign wrap     = ((CW'(n_ff) + CW'(1)) >= ww_ff) || (n_ff == '1);
   assign slot_inc = WW'(slot_ff) + WW'(1);

   // geometry, counters and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= WW'(W_RST);
         ww_ff   <= CW'(W_RST * W_RST);
         n_ff    <= '0;
         slot_ff <= '0;
         p_ff    <= '0;
         fill_ff <= '0;
      end else begin
         if (state_ff == SYNC_SETUP) begin
            w_ff <= clamp_width(cfg.grid_width);
         end
         if (state_ff == SYNC_MULT) begin
            ww_ff <= CW'(w_ff * w_ff);
         end
         if (state_ff == SYNC_DIVIDE && rem_done) begin
            slot_ff <= SW'(rem_value);
         end
         if (accept) begin
            p_ff <= p_ff + PW'(1);
            if (fill_ff != '1) begin
               fill_ff <= fill_ff + PW'(1);
            end
            if (wrap) begin
               n_ff    <= '0;
               slot_ff <= '0;
            end else begin
               n_ff <= n_ff + IDX_W'(1);
               if (slot_inc == w_ff) begin
                  slot_ff <= '0;
               end else begin
                  slot_ff <= SW'(slot_inc);
               end
            end
         end
      end
   end

   // mask memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (accept) begin
         mask_mem[p_ff] <= band;
      end
      ra_ff <= mask_mem[addr_a];
      rb_ff <= mask_mem[addr_b];
      va_ff <= val_a;
      vb_ff <= val_b;
   end

   // line store: read-first at the current slot
   always_ff @(posedge clock) begin
      line_rd_ff <= line_mem[slot_ff];
      if (accept) begin
         line_mem[slot_ff] <= req_tdata;
      end
   end

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         prime_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         prime_ff    <= prime_rd;
      end
      s1_band_ff  <= band;
      s1_nok_ff   <= n_ge;
      s1_index_ff <= n_ff - IDX_W'(w_ff);
   end

   assign ra_val = ra_ff && va_ff;
   assign rb_val = rb_ff && vb_ff;

   // older taps: shift the right tap along, or load both when priming
   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff <= 1'b0;
         a2_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         a1_ff <= ra_val;
         a2_ff <= a1_ff;
      end else if (prime_ff) begin
         a1_ff <= ra_val;
         a2_ff <= rb_val;
      end
   end

   // erosion decision: below, right, centre, left and above all in band
   assign emit = s1_valid_ff && s1_nok_ff && s1_band_ff && ra_val &&
                 a1_ff && a2_ff && rb_val;

   assign push.valid          = emit;
   assign push.data.sel_x     = line_rd_ff[POS_W-1:0];
   assign push.data.sel_y     = line_rd_ff[2*POS_W-1:POS_W];
   assign push.data.sel_z     = line_rd_ff[3*POS_W-1:2*POS_W];
   assign push.data.sel_index = s1_index_ff;

endmodule

FILE: design/hbes_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbes_queue: result queue
// Short register FIFO between the erosion decision and the result channel,
// so that a stalled receiver does not stop the intake at once.
// ----------------------------------------------------------------------------
module hbes_queue
   import hbes_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  hbes_push_type       push,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output hbes_result_type     rsp_word,
   output logic [LEVEL_W-1:0]  level
);

   hbes_result_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ff, rd_ff;
   logic [LEVEL_W-1:0]       level_ff;
   logic                     pop;

   assign pop = rsp_tvalid && rsp_tready;

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         if (push.valid) begin
            wr_ff <= wr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QUEUE_PTR_W'(1);
         end
         case ({push.valid, pop})
            2'b10:   level_ff <= level_ff + LEVEL_W'(1);
            2'b01:   level_ff <= level_ff - LEVEL_W'(1);
            default: level_ff <= level_ff;
         endcase
      end
   end

   assign rsp_tvalid = (level_ff != '0);
   assign rsp_word   = mem_ff[rd_ff];
   assign level      = level_ff;

endmodule

FILE: design/height_band_erosion_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_band_erosion_select: four-neighbor erosion of a height band mask
// Vertices of a square grid stream in raster order on req_; a vertex is
// forwarded on rsp_ when it and its row neighbors above and below and its
// linear neighbors left and right all have a height strictly inside the
// band set by min_height and max_height.
//
// Use:
//  - req_ carries one vertex word per cycle while req_tready is high,
//    which is the throughput; rsp_ carries zero or one result word per
//    accepted vertex, for the centre one row above it. rsp_tvalid rises
//    via the decision stage and the queue level register.
//  - A four-word result queue sits before rsp_; when the receiver stalls,
//    intake stops once the queued words plus the decision stage make four.
//  - Writing grid_width starts a resync (clamp of the width, its square,
//    a bit-serial remainder of the raster index by the new width) during
//    which req_tready is low. Other register writes take effect at once.
//  - Reset is synchronous; it restores the register defaults, clears the
//    counter and the band window. No clearing pass is needed: a fill
//    count marks which window entries hold data.
// ----------------------------------------------------------------------------
module height_band_erosion_select
   import hbes_pkg::*;
#(
   parameter int MAX_GRID_WIDTH = DEFAULT_MAX_GRID_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   // vertex words
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [95:0]        req_tdata,   // pos_x, pos_y, pos_z
   // result words
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [119:0]       rsp_tdata,   // sel_x, sel_y, sel_z, sel_index, zero pad
   // register writes
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic [GW_W-1:0]         grid_width_ff;
   logic signed [POS_W-1:0] min_height_ff;
   logic signed [POS_W-1:0] max_height_ff;
   logic                    width_wr_ff;

   hbes_cfg_type    cfg;
   hbes_push_type   push;
   hbes_result_type rsp_word;
   logic [LEVEL_W-1:0] q_level;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_WIDTH_RESET;
         min_height_ff <= MIN_HEIGHT_RESET;
         max_height_ff <= MAX_HEIGHT_RESET;
         width_wr_ff   <= 1'b0;
      end else begin
         width_wr_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_addr)
               REG_GRID_WIDTH: begin
                  grid_width_ff <= csr_wdata[GW_W-1:0];
                  width_wr_ff   <= 1'b1;
               end
               REG_MIN_HEIGHT: min_height_ff <= csr_wdata;
               REG_MAX_HEIGHT: max_height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign cfg.width_wr   = width_wr_ff;
   assign cfg.grid_width = grid_width_ff;
   assign cfg.min_height = min_height_ff;
   assign cfg.max_height = max_height_ff;

   hbes_front #(
      .MAX_GRID_WIDTH(MAX_GRID_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_level    (q_level),
      .push       (push)
   );

   hbes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word),
      .level      (q_level)
   );

   assign rsp_tdata = {4'b0, rsp_word};

   // queue never receives a word while full and not draining
   assert property (@(posedge clock) disable iff (reset)
      !(push.valid && (q_level == LEVEL_W'(QUEUE_DEPTH)) && !(rsp_tvalid && rsp_tready)))
      else $error("result queue overflow");

   // a result only follows an accepted vertex
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> $past(req_tvalid && req_tready))
      else $error("result without accepted vertex");

   // intake closes right after a width write
   assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_addr == REG_GRID_WIDTH)) |=> !req_tready)
      else $error("intake open during width resync");

endmodule
